// ===== design/ich_pkg.sv =====
`timescale 1ns / 1ps
package ich_pkg;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_MAP    = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  // Slot table size; a power of two so the hash reduces to its low bits.
  localparam int SLOT_COUNT = 8192;

  // Fibonacci hash multiplier, split into halves for two 32x32 products.
  localparam logic [31:0] HASH_MULT_LO = 32'h7F4A7C15;
  localparam logic [31:0] HASH_MULT_HI = 32'h9E3779B9;

endpackage

// ===== design/id_compaction_hash_table_core.sv =====
`timescale 1ns / 1ps
// Sequence: a reverse read passes through S_REV, S_REVW and S_OUT; a clear goes straight to S_OUT;
//   an insert hashes in S_HASH1 and S_HASH2, then runs S_REQ and S_CHK per probed slot; a map
//   edge hashes and probes both keys in turn in the same way before reaching S_OUT.
// Throughput: one word at a time; the next word is accepted once the result is taken.
// Reset: after rst_n, and after every clear operation, a sweep over all SLOT_COUNT (8192)
//   slots empties the slot-used memory; no word is accepted meanwhile.
module id_compaction_hash_table_core #(
  parameter int CAPACITY   = 4096,
  parameter int ID_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_key_a,
  input  logic [31:0] in_key_b,
  input  logic [11:0] in_local_index,
  input  logic        in_batch_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value_a,
  output logic [11:0] out_value_b,
  output logic        out_found_a,
  output logic        out_found_b,
  output logic        out_newly_added,
  output logic        out_table_full,
  output logic [12:0] out_entry_total,
  output logic        out_batch_done
);

  localparam int SW = $clog2(ich_pkg::SLOT_COUNT);
  localparam int CW = $clog2(CAPACITY);
  localparam int NW = $clog2(CAPACITY + 1);
  localparam int PW = $clog2(ich_pkg::SLOT_COUNT + 1);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_HASH1 = 9'b000000100,
    S_HASH2 = 9'b000001000,
    S_REQ   = 9'b000010000,
    S_CHK   = 9'b000100000,
    S_REV   = 9'b001000000,
    S_REVW  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  // Slot memory: key, local id and used bit in separate arrays, indexed by slot.
  logic [ID_BITS-1:0] key_mem [ich_pkg::SLOT_COUNT];
  logic [CW-1:0]      loc_mem [ich_pkg::SLOT_COUNT];
  logic               used_mem[ich_pkg::SLOT_COUNT];
  logic [ID_BITS-1:0] rev_mem [CAPACITY];

  state_t             state_r, state_nxt;
  logic [SW-1:0]      clr_r;
  logic [1:0]         func_r;
  logic [ID_BITS-1:0] kb_r, key_r;
  logic [11:0]        idx_r;
  logic               last_r;
  logic               second_r;
  logic [63:0]        plo_r;
  logic [31:0]        phi_r;
  logic [SW-1:0]      slot_r;
  logic [PW-1:0]      probes_r;
  logic [NW-1:0]      count_r;
  logic [ID_BITS-1:0] rd_key_r, rd_rev_r;
  logic [CW-1:0]      rd_loc_r;
  logic               rd_used_r;
  logic               ovalid_r;
  logic [31:0]        va_r;
  logic [11:0]        vb_r;
  logic               fa_r, fb_r, nadd_r, full_r;

  logic               wr_en;
  logic [SW-1:0]      wr_addr;
  logic               wr_used;
  logic [31:0]        key32;
  logic [63:0]        prod;
  logic [63:0]        hmix;

  assign in_ready = (state_r == S_IDLE) && !ovalid_r;
  // Keys never exceed the 32-bit port, so two 32x32 partial products cover the hash.
  assign key32 = 32'(key_r);
  assign prod  = plo_r + {phi_r, 32'b0};
  assign hmix  = prod ^ (prod >> 29);

  always_ff @(posedge clk) begin
    rd_key_r  <= key_mem[slot_r];
    rd_loc_r  <= loc_mem[slot_r];
    rd_used_r <= used_mem[slot_r];
    rd_rev_r  <= rev_mem[CW'(idx_r)];
    if (wr_en) begin
      used_mem[wr_addr] <= wr_used;
      if (wr_used) begin
        key_mem[wr_addr] <= key_r;
        loc_mem[wr_addr] <= count_r[CW-1:0];
        rev_mem[count_r[CW-1:0]] <= key_r;
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_r;
    wr_used = 1'b1;
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_used = 1'b0;
    end else if (state_r == S_CHK && func_r == ich_pkg::FUNC_INSERT && !rd_used_r
                 && count_r < NW'(CAPACITY)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid && out_ready) ovalid_r <= 1'b0;
      case (state_r)
        S_CLEAR: clr_r <= clr_r + 1'b1;
        S_IDLE: begin
          if (in_valid && in_ready) begin
            func_r   <= in_func;
            kb_r     <= ID_BITS'(in_key_b);
            key_r    <= ID_BITS'(in_key_a);
            idx_r    <= in_local_index;
            last_r   <= in_batch_last;
            second_r <= 1'b0;
            va_r <= '0; vb_r <= '0; fa_r <= 1'b0; fb_r <= 1'b0;
            nadd_r <= 1'b0; full_r <= 1'b0;
          end
        end
        S_HASH1: begin
          plo_r <= key32 * ich_pkg::HASH_MULT_LO;
          phi_r <= key32 * ich_pkg::HASH_MULT_HI;
        end
        S_HASH2: begin
          slot_r   <= hmix[SW-1:0];
          probes_r <= '0;
        end
        S_CHK: begin
          if (!rd_used_r) begin
            if (func_r == ich_pkg::FUNC_INSERT) begin
              if (count_r < NW'(CAPACITY)) begin
                va_r    <= 32'(count_r);
                nadd_r  <= 1'b1;
                count_r <= count_r + 1'b1;
              end else full_r <= 1'b1;
            end
            second_r <= 1'b1;
            key_r    <= kb_r;
          end else if (rd_key_r == key_r) begin
            if (func_r == ich_pkg::FUNC_MAP && second_r) begin
              vb_r <= 12'(rd_loc_r); fb_r <= 1'b1;
            end else begin
              va_r <= 32'(rd_loc_r); fa_r <= 1'b1;
            end
            second_r <= 1'b1;
            key_r    <= kb_r;
          end else if (probes_r == PW'(ich_pkg::SLOT_COUNT - 1)) begin
            if (func_r == ich_pkg::FUNC_INSERT) full_r <= 1'b1;
            second_r <= 1'b1;
            key_r    <= kb_r;
          end else begin
            slot_r   <= slot_r + 1'b1;
            probes_r <= probes_r + 1'b1;
          end
        end
        S_REVW: begin
          if (32'(idx_r) < 32'(count_r)) begin
            va_r <= 32'(rd_rev_r); fa_r <= 1'b1;
          end
        end
        S_OUT: begin
          if (func_r == ich_pkg::FUNC_CLEAR) count_r <= '0;
          ovalid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == SW'(ich_pkg::SLOT_COUNT - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_func == ich_pkg::FUNC_READ) state_nxt = S_REV;
          else if (in_func == ich_pkg::FUNC_CLEAR) state_nxt = S_OUT;
          else state_nxt = S_HASH1;
        end
      end
      S_HASH1: state_nxt = S_HASH2;
      S_HASH2: state_nxt = S_REQ;
      S_REQ:   state_nxt = S_CHK;
      S_CHK: begin
        if (!rd_used_r || rd_key_r == key_r
            || probes_r == PW'(ich_pkg::SLOT_COUNT - 1)) begin
          if (func_r == ich_pkg::FUNC_MAP && !second_r) state_nxt = S_HASH1;
          else state_nxt = S_OUT;
        end else state_nxt = S_REQ;
      end
      S_REV:  state_nxt = S_REVW;
      S_REVW: state_nxt = S_OUT;
      // Clear restarts the used-bit sweep once the result is posted.
      S_OUT:  state_nxt = (func_r == ich_pkg::FUNC_CLEAR) ? S_CLEAR : S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign out_valid       = ovalid_r;
  assign out_value_a     = va_r;
  assign out_value_b     = vb_r;
  assign out_found_a     = fa_r;
  assign out_found_b     = fb_r;
  assign out_newly_added = nadd_r;
  assign out_table_full  = full_r;
  assign out_entry_total = 13'(count_r);
  assign out_batch_done  = last_r;

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready) else $error("accept during sweep");
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(CAPACITY)) else $error("count over capacity");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_newly_added && out_table_full)) else $error("flag clash");

endmodule
